[src/spm_pkg.sv]
// ----------------------------------------------------------------------------
// spm_pkg: shared types and constants of the subbuffer pool manager
// Field widths, operation codes and status codes.
// ----------------------------------------------------------------------------
package spm_pkg;
  localparam int NumBuffers = 16;
  localparam int RingCap = (NumBuffers < 16) ? NumBuffers : 16;
  localparam int IdxW = 4;
  localparam int LvlW = 5;
  localparam int BytesW = 21;
  localparam int OffW = 20;

  localparam logic [2:0] KIND_RESERVE = 3'd0;
  localparam logic [2:0] KIND_POP     = 3'd1;
  localparam logic [2:0] KIND_PUSH    = 3'd2;
  localparam logic [2:0] KIND_RETURN  = 3'd3;
  localparam logic [2:0] KIND_MARK    = 3'd4;
  localparam logic [2:0] KIND_RELEASE = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] RT_NOTICE = 2'd0;
  localparam logic [1:0] RT_ANSWER = 2'd1;

  localparam logic [LvlW-1:0] CAP = LvlW'(RingCap);

  typedef logic [IdxW-1:0] idx_t;

  // advance a ring pointer modulo the ring capacity
  function automatic idx_t ring_add(idx_t a, logic [LvlW-1:0] b);
    logic [LvlW:0] s;
    s = {2'b0, a} + {1'b0, b};
    if (s >= {1'b0, CAP}) s = s - {1'b0, CAP};
    if (s >= {1'b0, CAP}) s = s - {1'b0, CAP};
    return s[IdxW-1:0];
  endfunction
endpackage

[src/spm_room_unit.sv]
// ----------------------------------------------------------------------------
// spm_room_unit: shared compare/add unit
// Computes the room check for a head buffer and its next fill level.
// ----------------------------------------------------------------------------
module spm_room_unit (
  input  logic [spm_pkg::BytesW-1:0] cap,
  input  logic [spm_pkg::BytesW-1:0] fill,
  input  logic [spm_pkg::BytesW-1:0] req,
  output logic                       fits,
  output logic [spm_pkg::BytesW-1:0] fill_next
);
  import spm_pkg::*;
  logic [BytesW-1:0] room;

  always_comb begin
    room = (cap >= fill) ? cap - fill : '0;
    fits = room >= req;
    fill_next = fill + req;
  end
endmodule

[src/subbuffer_pool_manager_top.sv]
// ----------------------------------------------------------------------------
// subbuffer_pool_manager_top: pool of subbuffers in write/read queues
// Sequenced manager of a write queue, a read queue and a busy set.
// ----------------------------------------------------------------------------
// Usage: raise start with kind, request_bytes and buffer_number while busy
// is low; the word is taken at that edge and busy rises the next cycle.
// Each result word shows for one cycle with valid high; last marks the
// final word of the command. The receiver cannot stall.
// Timing: a command is loaded first, then its result words follow. A reserve
// visits one write-queue head per cycle through the shared room unit and
// gives a notice word for each head that it moves; a release searches the
// busy set one entry per cycle. Other commands give a single word. The next
// start is taken at the edge that ends the cycle of the last word.
// Reset (rst, synchronous) restores the pool: capacity 4096, all 16 buffers
// in the write queue with zero fill, read queue and busy set empty. Writing
// register 1 does likewise, keeping capacity, with min(data[4:0],16) buffers.
// Config: cfg_we, cfg_index, cfg_data; write only while busy is low.
// ----------------------------------------------------------------------------
module subbuffer_pool_manager_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 kind,
  input  logic [spm_pkg::BytesW-1:0] request_bytes,
  input  logic [spm_pkg::IdxW-1:0]   buffer_number,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [spm_pkg::BytesW-1:0] cfg_data,
  output logic                       valid,
  output logic [1:0]                 result_type,
  output logic [1:0]                 status,
  output logic [spm_pkg::IdxW-1:0]   granted_buffer,
  output logic [spm_pkg::OffW-1:0]   write_offset,
  output logic [spm_pkg::LvlW-1:0]   busy_entries,
  output logic                       last
);
  import spm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SRCH = 2'd2;

  logic [1:0] state;
  logic [BytesW-1:0] cap;

  idx_t write_ring [16];
  idx_t read_ring [16];
  idx_t busy_table [16];
  logic [BytesW-1:0] fill_bytes [16];
  idx_t write_head, read_head;
  logic [LvlW-1:0] write_level, read_level, busy_level;

  logic [2:0] op;
  logic [BytesW-1:0] req;
  idx_t bn;
  logic [LvlW-1:0] srch;

  logic fits;
  logic [BytesW-1:0] fill_next;
  idx_t head_buf;
  logic bn_ok;
  logic [LvlW-1:0] init_n;

  assign head_buf = write_ring[write_head];
  assign bn_ok = {1'b0, bn} < CAP;
  assign busy = (state != S_IDLE);
  assign init_n = (cfg_data[LvlW-1:0] > CAP) ? CAP : cfg_data[LvlW-1:0];

  spm_room_unit u_room (
    .cap      (cap),
    .fill     (fill_bytes[head_buf]),
    .req      (req),
    .fits     (fits),
    .fill_next(fill_next)
  );

  // emit one result word
  task automatic put(input logic [1:0] t, input logic [1:0] s, input idx_t b,
                     input logic [OffW-1:0] o, input logic [LvlW-1:0] bl,
                     input logic l);
    valid <= 1'b1;
    result_type <= t;
    status <= s;
    granted_buffer <= b;
    write_offset <= o;
    busy_entries <= bl;
    last <= l;
  endtask

  always_ff @(posedge clk) begin
    valid <= 1'b0;
    if (rst || (cfg_we && cfg_index == 1'b1 && state == S_IDLE)) begin
      if (rst) begin
        cap <= BytesW'(4096);
        write_level <= CAP;
      end else begin
        write_level <= init_n;
      end
      for (int i = 0; i < 16; i++) begin
        write_ring[i] <= IdxW'(i);
        fill_bytes[i] <= '0;
      end
      write_head <= '0;
      read_head <= '0;
      read_level <= '0;
      busy_level <= '0;
      state <= S_IDLE;
    end else begin
      if (cfg_we && cfg_index == 1'b0) cap <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op <= kind;
            req <= request_bytes;
            bn <= buffer_number;
            srch <= '0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_IDLE;
          case (op)
            KIND_RESERVE: begin
              if (write_level == '0) begin
                put(RT_ANSWER, ST_EMPTY, '0, '0, busy_level, 1'b1);
              end else if (fits) begin
                fill_bytes[head_buf] <= fill_next;
                put(RT_ANSWER, ST_OK, head_buf, fill_bytes[head_buf][OffW-1:0],
                    busy_level, 1'b1);
              end else begin
                // move the head to the read queue if it has room and keep scanning
                write_head <= ring_add(write_head, LvlW'(1));
                write_level <= write_level - 1'b1;
                if (read_level < CAP) begin
                  read_ring[ring_add(read_head, read_level)] <= head_buf;
                  read_level <= read_level + 1'b1;
                  put(RT_NOTICE, ST_OK, head_buf, '0, busy_level, 1'b0);
                end else begin
                  put(RT_NOTICE, ST_FULL, head_buf, '0, busy_level, 1'b0);
                end
                state <= S_EXEC;
              end
            end
            KIND_POP: begin
              if (read_level == '0) begin
                put(RT_ANSWER, ST_EMPTY, '0, '0, busy_level, 1'b1);
              end else begin
                read_head <= ring_add(read_head, LvlW'(1));
                read_level <= read_level - 1'b1;
                put(RT_ANSWER, ST_OK, read_ring[read_head], '0, busy_level, 1'b1);
              end
            end
            KIND_PUSH: begin
              if (!bn_ok) put(RT_ANSWER, ST_EMPTY, '0, '0, busy_level, 1'b1);
              else if (read_level >= CAP) put(RT_ANSWER, ST_FULL, '0, '0, busy_level, 1'b1);
              else begin
                read_ring[ring_add(read_head, read_level)] <= bn;
                read_level <= read_level + 1'b1;
                put(RT_ANSWER, ST_OK, bn, '0, busy_level, 1'b1);
              end
            end
            KIND_RETURN: begin
              if (!bn_ok) put(RT_ANSWER, ST_EMPTY, '0, '0, busy_level, 1'b1);
              else if (write_level >= CAP) put(RT_ANSWER, ST_FULL, '0, '0, busy_level, 1'b1);
              else begin
                fill_bytes[bn] <= '0;
                write_ring[ring_add(write_head, write_level)] <= bn;
                write_level <= write_level + 1'b1;
                put(RT_ANSWER, ST_OK, bn, '0, busy_level, 1'b1);
              end
            end
            KIND_MARK: begin
              if (!bn_ok) put(RT_ANSWER, ST_EMPTY, '0, '0, busy_level, 1'b1);
              else if (busy_level >= CAP) put(RT_ANSWER, ST_FULL, '0, '0, busy_level, 1'b1);
              else begin
                busy_table[busy_level[IdxW-1:0]] <= bn;
                busy_level <= busy_level + 1'b1;
                put(RT_ANSWER, ST_OK, bn, '0, busy_level + 1'b1, 1'b1);
              end
            end
            KIND_RELEASE: begin
              if (!bn_ok) put(RT_ANSWER, ST_EMPTY, '0, '0, busy_level, 1'b1);
              else state <= S_SRCH;
            end
            default: put(RT_ANSWER, ST_EMPTY, '0, '0, busy_level, 1'b1);
          endcase
        end
        S_SRCH: begin
          // one busy entry per cycle; first match takes the last entry
          if (srch >= busy_level) begin
            put(RT_ANSWER, ST_EMPTY, '0, '0, busy_level, 1'b1);
            state <= S_IDLE;
          end else if (busy_table[srch[IdxW-1:0]] == bn) begin
            busy_table[srch[IdxW-1:0]] <= busy_table[IdxW'(busy_level - 1'b1)];
            busy_level <= busy_level - 1'b1;
            put(RT_ANSWER, ST_OK, bn, '0, busy_level - 1'b1, 1'b1);
            state <= S_IDLE;
          end else begin
            srch <= srch + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[tb/sv/tb_subbuffer_pool_manager_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_subbuffer_pool_manager_top: self-checking bench of the pool manager
// Drives directed and random commands in bursts, predicts every result word
// from a behavioral copy of the pool and compares each whole word.
// ----------------------------------------------------------------------------
module tb_subbuffer_pool_manager_top;
  import spm_pkg::*;

  typedef struct packed {
    logic [2:0]        kind;
    logic [BytesW-1:0] req;
    logic [IdxW-1:0]   bnum;
  } command_t;

  typedef struct packed {
    logic [1:0]      rtype;
    logic [1:0]      stat;
    logic [IdxW-1:0] buf_id;
    logic [OffW-1:0] offset;
    logic [LvlW-1:0] busy_cnt;
    logic            lst;
  } word_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [2:0]        kind;
  logic [BytesW-1:0] request_bytes;
  logic [IdxW-1:0]   buffer_number;
  logic              cfg_we;
  logic              cfg_index;
  logic [BytesW-1:0] cfg_data;
  logic              valid;
  logic [1:0]        result_type;
  logic [1:0]        status;
  logic [IdxW-1:0]   granted_buffer;
  logic [OffW-1:0]   write_offset;
  logic [LvlW-1:0]   busy_entries;
  logic              last;

  subbuffer_pool_manager_top dut (.*);

  // pool shadow: queues, fill levels and busy set as the block keeps them
  logic [BytesW-1:0] cap_bytes;
  logic [LvlW-1:0]   init_count;
  logic [IdxW-1:0]   wr_ring [16];
  logic [IdxW-1:0]   rd_ring [16];
  logic [IdxW-1:0]   busy_set [16];
  logic [BytesW-1:0] fill [16];
  int                wr_head, wr_lvl, rd_head, rd_lvl, busy_lvl;

  command_t pending_cmds[$];
  word_t    expected_words[$];
  int       mismatches;
  longint   cycle_count;
  logic     drive_en;
  int       burst_left, gap_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // rebuild the pool as reset or a count write does
  task automatic pool_init();
    int n;
    n = (init_count > RingCap) ? RingCap : init_count;
    for (int i = 0; i < 16; i++) begin
      wr_ring[i] = IdxW'(i);
      rd_ring[i] = '0;
      busy_set[i] = '0;
      fill[i] = '0;
    end
    wr_head = 0;
    wr_lvl = n;
    rd_head = 0;
    rd_lvl = 0;
    busy_lvl = 0;
  endtask

  task automatic add_word(logic [1:0] rt, logic [1:0] st, int b, int off, logic l);
    word_t w;
    w.rtype = rt;
    w.stat = st;
    w.buf_id = IdxW'(b);
    w.offset = OffW'(off);
    w.busy_cnt = LvlW'(busy_lvl);
    w.lst = l;
    expected_words.push_back(w);
  endtask

  // work out the result words of one accepted command
  task automatic predict_pool_words(command_t c);
    int  h, f, room, idx;
    logic ok, found;
    ok = c.bnum < RingCap;
    case (c.kind)
      KIND_RESERVE: begin
        found = 1'b0;
        while (wr_lvl > 0 && !found) begin
          h = wr_ring[wr_head % RingCap];
          f = fill[h];
          room = (cap_bytes >= f) ? cap_bytes - f : 0;
          if (room >= c.req) begin
            fill[h] = BytesW'(f + c.req);
            add_word(RT_ANSWER, ST_OK, h, f, 1'b1);
            found = 1'b1;
          end else begin
            wr_head = (wr_head + 1) % RingCap;
            wr_lvl--;
            if (rd_lvl < RingCap) begin
              rd_ring[(rd_head + rd_lvl) % RingCap] = IdxW'(h);
              rd_lvl++;
              add_word(RT_NOTICE, ST_OK, h, 0, 1'b0);
            end else begin
              add_word(RT_NOTICE, ST_FULL, h, 0, 1'b0);
            end
          end
        end
        if (!found) add_word(RT_ANSWER, ST_EMPTY, 0, 0, 1'b1);
      end
      KIND_POP: begin
        if (rd_lvl == 0) add_word(RT_ANSWER, ST_EMPTY, 0, 0, 1'b1);
        else begin
          h = rd_ring[rd_head % RingCap];
          rd_head = (rd_head + 1) % RingCap;
          rd_lvl--;
          add_word(RT_ANSWER, ST_OK, h, 0, 1'b1);
        end
      end
      KIND_PUSH: begin
        if (!ok) add_word(RT_ANSWER, ST_EMPTY, 0, 0, 1'b1);
        else if (rd_lvl >= RingCap) add_word(RT_ANSWER, ST_FULL, 0, 0, 1'b1);
        else begin
          rd_ring[(rd_head + rd_lvl) % RingCap] = c.bnum;
          rd_lvl++;
          add_word(RT_ANSWER, ST_OK, c.bnum, 0, 1'b1);
        end
      end
      KIND_RETURN: begin
        if (!ok) add_word(RT_ANSWER, ST_EMPTY, 0, 0, 1'b1);
        else if (wr_lvl >= RingCap) add_word(RT_ANSWER, ST_FULL, 0, 0, 1'b1);
        else begin
          fill[c.bnum] = '0;
          wr_ring[(wr_head + wr_lvl) % RingCap] = c.bnum;
          wr_lvl++;
          add_word(RT_ANSWER, ST_OK, c.bnum, 0, 1'b1);
        end
      end
      KIND_MARK: begin
        if (!ok) add_word(RT_ANSWER, ST_EMPTY, 0, 0, 1'b1);
        else if (busy_lvl >= RingCap) add_word(RT_ANSWER, ST_FULL, 0, 0, 1'b1);
        else begin
          busy_set[busy_lvl] = c.bnum;
          busy_lvl++;
          add_word(RT_ANSWER, ST_OK, c.bnum, 0, 1'b1);
        end
      end
      KIND_RELEASE: begin
        idx = -1;
        if (ok)
          for (int i = 0; i < busy_lvl && idx < 0; i++)
            if (busy_set[i] == c.bnum) idx = i;
        if (idx >= 0) begin
          // fill the hole with the last entry
          busy_set[idx] = busy_set[(busy_lvl - 1) & 15];
          busy_lvl--;
          add_word(RT_ANSWER, ST_OK, c.bnum, 0, 1'b1);
        end else begin
          add_word(RT_ANSWER, ST_EMPTY, 0, 0, 1'b1);
        end
      end
      default: add_word(RT_ANSWER, ST_EMPTY, 0, 0, 1'b1);
    endcase
  endtask

  function automatic command_t mk(logic [2:0] k, int r, int b);
    command_t c;
    c.kind = k;
    c.req = BytesW'(r);
    c.bnum = IdxW'(b);
    return c;
  endfunction

  // mostly well-formed traffic: reserves with sizes up to the capacity,
  // returns and pops to keep buffers cycling, busy marks and releases
  function automatic command_t rand_cmd();
    int sel, r;
    sel = $urandom_range(0, 99);
    if ($urandom_range(0, 9) == 0) r = $urandom_range(0, (1 << BytesW) - 1);
    else if ($urandom_range(0, 3) == 0) r = cap_bytes;
    else r = $urandom_range(0, cap_bytes);
    if (sel < 35) return mk(KIND_RESERVE, r, 0);
    if (sel < 50) return mk(KIND_POP, 0, 0);
    if (sel < 57) return mk(KIND_PUSH, $urandom, $urandom_range(0, 15));
    if (sel < 72) return mk(KIND_RETURN, $urandom, $urandom_range(0, 15));
    if (sel < 85) return mk(KIND_MARK, $urandom, $urandom_range(0, 15));
    if (sel < 97) return mk(KIND_RELEASE, $urandom, $urandom_range(0, 15));
    return mk(3'($urandom_range(6, 7)), $urandom, $urandom);
  endfunction

  // driver: feed the pending queue in bursts with random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      kind <= '0;
      request_bytes <= '0;
      buffer_number <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        predict_pool_words({kind, request_bytes, buffer_number});
      end
      if (start && !busy || !start) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (drive_en && pending_cmds.size() > 0) begin
          command_t c;
          c = pending_cmds.pop_front();
          start <= 1'b1;
          kind <= c.kind;
          request_bytes <= c.req;
          buffer_number <= c.bnum;
          if (burst_left <= 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed word is checked against the oldest expectation
  always @(posedge clk) begin
    if (!rst && valid) begin
      word_t got, want;
      got = '{result_type, status, granted_buffer, write_offset, busy_entries, last};
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", got);
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("word mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // hard stop if the pool hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || start || busy || expected_words.size() > 0)
      @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= BytesW'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == 1'b0) cap_bytes = BytesW'(val);
    else begin
      init_count = LvlW'(val);
      pool_init();
    end
  endtask

  initial begin
    int sizes[5] = '{4096, 1, 1048576, 100, 4096};
    int counts[5] = '{16, 1, 16, 3, 9};
    mismatches = 0;
    cycle_count = 0;
    drive_en = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    cap_bytes = 4096;
    init_count = 16;
    pool_init();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every kind, invalid kinds, overflow of fill, full stores
    pending_cmds.push_back(mk(KIND_POP, 0, 0));
    pending_cmds.push_back(mk(KIND_RESERVE, 0, 0));
    pending_cmds.push_back(mk(KIND_RESERVE, 4096, 0));
    pending_cmds.push_back(mk(KIND_RESERVE, 1, 0));
    pending_cmds.push_back(mk(KIND_RESERVE, 4000, 0));
    pending_cmds.push_back(mk(KIND_RESERVE, 2097151, 0));
    pending_cmds.push_back(mk(KIND_POP, 0, 0));
    pending_cmds.push_back(mk(KIND_RETURN, 0, 15));
    pending_cmds.push_back(mk(KIND_PUSH, 0, 15));
    pending_cmds.push_back(mk(KIND_MARK, 0, 5));
    pending_cmds.push_back(mk(KIND_MARK, 0, 5));
    pending_cmds.push_back(mk(KIND_RELEASE, 0, 7));
    pending_cmds.push_back(mk(KIND_RELEASE, 0, 5));
    pending_cmds.push_back(mk(3'd6, 2097151, 15));
    pending_cmds.push_back(mk(3'd7, 0, 0));
    for (int i = 0; i < 17; i++) pending_cmds.push_back(mk(KIND_MARK, 0, i & 15));
    for (int i = 0; i < 3; i++) pending_cmds.push_back(mk(KIND_PUSH, 0, i));
    drive_en = 1'b1;
    wait_drained();

    // largest size, zero reserve on an exactly full buffer
    write_reg(1'b0, 1048576);
    write_reg(1'b1, 31);
    pending_cmds.push_back(mk(KIND_RESERVE, 1048576, 0));
    pending_cmds.push_back(mk(KIND_RESERVE, 0, 0));
    pending_cmds.push_back(mk(KIND_RESERVE, 1, 0));
    wait_drained();

    // random phases under several settings; each drains before the write
    foreach (sizes[p]) begin
      write_reg(1'b0, sizes[p]);
      write_reg(1'b1, counts[p]);
      for (int i = 0; i < 85; i++) pending_cmds.push_back(rand_cmd());
      wait_drained();
    end

    if (expected_words.size() == 0 && mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
